@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/dpp_pkg.sv @@
// Shared constants and types of the depth pixel to point block.
`timescale 1ns / 1ps

package dpp_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;

  localparam int COL_W = 10;
  localparam int ROW_W = 9;

  // Inverse range w in Q8.24, signed.
  localparam int W_W   = 44;
  // Divisor magnitude and divider remainder width.
  localparam int REM_W = 43;
  // Dividend magnitude: |delta * scale| shifted up by 12.
  localparam int MAG_W = 58;
  localparam int Q_W   = 32;

  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [2:0] {
    CFG_SCALE_X      = 3'd0,
    CFG_SCALE_Y      = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_DEPTH_GAIN   = 3'd4,
    CFG_DEPTH_OFFSET = 3'd5
  } cfg_idx_t;

  localparam logic [31:0] RST_SCALE_X      = 32'd28235;
  localparam logic [31:0] RST_SCALE_Y      = 32'd28386;
  localparam logic [13:0] RST_CENTER_X     = 14'd5432;
  localparam logic [13:0] RST_CENTER_Y     = 14'd3883;
  localparam logic [31:0] RST_DEPTH_GAIN   = 32'hFFFF_36BB;
  localparam logic [31:0] RST_DEPTH_OFFSET = 32'd55884059;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } pos_t;

endpackage

@@ hdl/dpp_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module dpp_mul
  import dpp_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

@@ hdl/dpp_div.sv @@
// Bit-serial restoring divider with signed, saturated 32-bit quotient.
`timescale 1ns / 1ps

module dpp_div
  import dpp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [REM_W-1:0] divisor,
  output div_rsp_t         rsp
);

  logic             busy_r, busy_nxt;
  logic             fin_r, fin_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   dvd_r, dvd_nxt;
  logic [Q_W-1:0]   quot_r, quot_nxt;
  logic             ovf_r, ovf_nxt;
  logic             neg_r, neg_nxt;

  logic [REM_W:0]   shifted;
  logic [REM_W+1:0] diff;
  logic             ge;
  logic [REM_W-1:0] rem_init;

  assign rem_init = {{(REM_W-(MAG_W-Q_W)){1'b0}}, req.mag[MAG_W-1:Q_W]};
  assign shifted  = {rem_r, dvd_r[Q_W-1]};
  assign diff     = {1'b0, shifted} - {2'b0, divisor};
  assign ge       = !diff[REM_W+1];

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    ovf_nxt  = ovf_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = rem_init;
      dvd_nxt  = req.mag[Q_W-1:0];
      quot_nxt = '0;
      // quotient of 2^32 or more saturates either way
      ovf_nxt  = rem_init >= divisor;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      dvd_nxt  = {dvd_r[Q_W-2:0], 1'b0};
      quot_nxt = {quot_r[Q_W-2:0], ge};
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    ovf_r  <= ovf_nxt;
    neg_r  <= neg_nxt;
  end

  // Apply sign and clamp to the 32-bit signed range.
  always_comb begin
    rsp.done = fin_r;
    if (ovf_r) begin
      rsp.quot = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg_r) begin
      rsp.quot = (quot_r > 32'h8000_0000) ? 32'h8000_0000 : (~quot_r + 32'd1);
    end else begin
      rsp.quot = quot_r[Q_W-1] ? 32'h7FFF_FFFF : quot_r;
    end
  end

endmodule

@@ hdl/dpp_pos.sv @@
// Raster row and column counters with frame start and wrap.
`timescale 1ns / 1ps

module dpp_pos
  import dpp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic frame_start,
  output pos_t pos
);

  logic [COL_W-1:0] col_r, col_nxt, cur_col, col_inc;
  logic [ROW_W-1:0] row_r, row_nxt, cur_row, row_inc;

  assign cur_col = frame_start ? '0 : col_r;
  assign cur_row = frame_start ? '0 : row_r;
  assign col_inc = cur_col + 1'b1;
  assign row_inc = cur_row + 1'b1;

  assign pos.col  = cur_col;
  assign pos.row  = cur_row;
  assign pos.last = (cur_col == COL_W'(FRAME_WIDTH - 1)) &&
                    (cur_row == ROW_W'(FRAME_HEIGHT - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (adv) begin
      col_nxt = col_inc;
      row_nxt = cur_row;
      if (col_inc >= COL_W'(FRAME_WIDTH) || col_inc == '0) begin
        col_nxt = '0;
        row_nxt = (row_inc >= ROW_W'(FRAME_HEIGHT)) ? '0 : row_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ hdl/depth_pixel_to_point.sv @@
// Top level: pinhole back-projection of a raster depth stream to points.
//
// Input stream: one item per pixel in raster order. in_tdata carries the raw
// depth and the RGB bytes, in_tuser the frame start flag, which puts the
// position counters back to row 0 column 0 before the pixel is used.
// Output stream: one item per input item, same order: x, y, z in signed
// Q16.16 with the colour in out_tdata, the valid flag in out_tuser and the
// last pixel of the frame on out_tlast. Zero or negative w gives a zero,
// invalid point.
// Steps: a valid pixel forms w through the shared multiplier, then three
// 32-step quotients, x, y and z, one after another through one bit-serial
// divider; an invalid pixel skips the divider. The block takes no new item
// before the result of the last one is in the output register.
// The block takes a new item while the previous result waits in the output
// register; a stalled receiver holds the block at its final step.
// Reset (synchronous, rst_n low) clears the counters and the handshake and
// loads the calibration defaults into the registers.
// cfg_we writes cfg_wdata to register cfg_index at once; unknown indexes
// are ignored. Write only while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module depth_pixel_to_point
  import dpp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // depth_sample[10:0], pixel_red[18:11], pixel_green[26:19],
  // pixel_blue[34:27], zero fill [39:35]
  input  logic [39:0]  in_tdata,
  // frame_start[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64], point_red[103:96],
  // point_green[111:104], point_blue[119:112]
  output logic [119:0] out_tdata,
  // point_valid[0]
  output logic         out_tuser,
  output logic         out_tlast
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MULW = 7'b0000010,
    S_ADDW = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_LOAD = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    PH_X = 2'd0,
    PH_Y = 2'd1,
    PH_Z = 2'd2
  } phase_t;

  localparam logic [MAG_W-1:0] Z_MAG = MAG_W'(1) << 40;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [31:0] scale_x_r, scale_y_r, gain_r, offset_r;
  logic [13:0] center_x_r, center_y_r;

  logic [10:0]      depth_r;
  logic [7:0]       red_r, green_r, blue_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             last_r;
  logic signed [W_W-1:0] w_r, w_nxt;
  logic [Q_W-1:0]   px_r, py_r, pz_r;
  logic             valid_r;

  logic             out_valid_r, out_valid_nxt;
  logic [119:0]     out_data_r;
  logic             out_user_r, out_last_r;

  logic                      in_acc;
  logic                      out_load;
  pos_t                      pos;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [MUL_A_W-1:0] dx, dy;
  logic [MUL_P_W-1:0]        prod_abs;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic                      w_bad;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r  <= RST_SCALE_X;
      scale_y_r  <= RST_SCALE_Y;
      center_x_r <= RST_CENTER_X;
      center_y_r <= RST_CENTER_Y;
      gain_r     <= RST_DEPTH_GAIN;
      offset_r   <= RST_DEPTH_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE_X:      scale_x_r  <= cfg_wdata;
        CFG_SCALE_Y:      scale_y_r  <= cfg_wdata;
        CFG_CENTER_X:     center_x_r <= cfg_wdata[13:0];
        CFG_CENTER_Y:     center_y_r <= cfg_wdata[13:0];
        CFG_DEPTH_GAIN:   gain_r     <= cfg_wdata;
        CFG_DEPTH_OFFSET: offset_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dpp_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (in_acc),
    .frame_start (in_tuser),
    .pos         (pos)
  );

  assign dx = {2'b0, col_r, 4'b0} - {2'b0, center_x_r};
  assign dy = {2'b0, center_y_r} - {{(MUL_A_W-ROW_W-4){1'b0}}, row_r, 4'b0};

  always_comb begin
    mul_a = dx;
    mul_b = scale_x_r;
    if (state_r == S_MULW) begin
      mul_a = {{(MUL_A_W-11){1'b0}}, depth_r};
      mul_b = gain_r;
    end else if (phase_r == PH_Y) begin
      mul_a = dy;
      mul_b = scale_y_r;
    end
  end

  dpp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  assign prod_abs = prod_r[MUL_P_W-1] ? (~prod_r + 1'b1) : prod_r;
  assign w_bad    = w_r[W_W-1] || (w_r == '0);

  always_comb begin
    div_req.start = (state_r == S_LOAD);
    if (phase_r == PH_Z) begin
      div_req.neg = 1'b1;
      div_req.mag = Z_MAG;
    end else begin
      div_req.neg = prod_r[MUL_P_W-1];
      div_req.mag = {prod_abs[MAG_W-13:0], 12'b0};
    end
  end

  dpp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (w_r[REM_W-1:0]),
    .rsp     (div_rsp)
  );

  assign w_nxt = prod_r[W_W-1:0] + {{(W_W-32){offset_r[31]}}, offset_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_MULW;
      S_MULW: state_nxt = S_ADDW;
      S_ADDW: begin
        state_nxt = S_MUL;
        phase_nxt = PH_X;
      end
      S_MUL:  state_nxt = w_bad ? S_OUT : S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          if (phase_r == PH_Z) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_MUL;
            phase_nxt = (phase_r == PH_X) ? PH_Y : PH_Z;
          end
        end
      end
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_X;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // item payload and results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      depth_r <= in_tdata[10:0];
      red_r   <= in_tdata[18:11];
      green_r <= in_tdata[26:19];
      blue_r  <= in_tdata[34:27];
      col_r   <= pos.col;
      row_r   <= pos.row;
      last_r  <= pos.last;
    end
    if (state_r == S_ADDW) begin
      w_r <= w_nxt;
    end
    if (state_r == S_MUL) begin
      valid_r <= !w_bad;
      if (w_bad) begin
        px_r <= '0;
        py_r <= '0;
        pz_r <= '0;
      end
    end
    if (state_r == S_DIV && div_rsp.done) begin
      unique case (phase_r)
        PH_X:    px_r <= div_rsp.quot;
        PH_Y:    py_r <= div_rsp.quot;
        default: pz_r <= div_rsp.quot;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_data_r <= {blue_r, green_r, red_r, pz_r, py_r, px_r};
      out_user_r <= valid_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `ASSERT_CLK(a_done_in_div, div_rsp.done |-> state_r == S_DIV, "quotient outside divide step")
  `ASSERT_CLK(a_invalid_zero, out_tvalid && !out_tuser |-> out_tdata[95:0] == 96'd0, "invalid point not zero")
  `ASSERT_CLK(a_z_nonpos, out_tvalid && out_tuser |-> out_tdata[95] || out_tdata[95:64] == 32'd0, "valid z positive")

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the depth pixel to point block.
`timescale 1ns / 1ps

module tb;
  import dpp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_GAP = 18;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 150;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 182;
  localparam int REPORT_CAP = 200;
  // Register indexes the block does not decode.
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        valid;
    logic        last;
  } point_t;

  // Projects each accepted pixel and checks the points in arrival order.
  class point_tracker;
    int scale_x;
    int scale_y;
    int center_x;
    int center_y;
    int gain;
    int offset;
    int col;
    int row;
    int checked;
    int mismatches;
    point_t expected_q[$];

    function new();
      scale_x = RST_SCALE_X;
      scale_y = RST_SCALE_Y;
      center_x = RST_CENTER_X;
      center_y = RST_CENTER_Y;
      gain = RST_DEPTH_GAIN;
      offset = RST_DEPTH_OFFSET;
      col = 0;
      row = 0;
      checked = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_SCALE_X:      scale_x = val;
        CFG_SCALE_Y:      scale_y = val;
        CFG_CENTER_X:     center_x = val[13:0];
        CFG_CENTER_Y:     center_y = val[13:0];
        CFG_DEPTH_GAIN:   gain = val;
        CFG_DEPTH_OFFSET: offset = val;
        default: ;
      endcase
    endfunction

    // Truncate toward zero, then clamp to the signed 32-bit range.
    function longint clip_quotient(bit neg, longint unsigned mag, longint unsigned w);
      longint unsigned q;
      q = mag / w;
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return -longint'(q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return longint'(q);
    endfunction

    // delta in 1/16 pixel times Q8.24 scale over Q8.24 w gives Q16.16.
    function longint project_axis(longint delta, int scale, longint unsigned w);
      longint prod;
      longint unsigned mag;
      prod = delta * longint'(scale);
      mag = (prod < 0) ? -prod : prod;
      return clip_quotient(prod < 0, mag << 12, w);
    endfunction

    function void note_pixel(logic [10:0] depth, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic start);
      point_t p;
      longint w;
      if (start) begin
        col = 0;
        row = 0;
      end
      p = '0;
      w = longint'(gain) * longint'(depth) + longint'(offset);
      if (w > 0) begin
        p.x = 32'(project_axis(longint'(col) * 16 - longint'(center_x), scale_x, w));
        p.y = 32'(project_axis(longint'(center_y) - longint'(row) * 16, scale_y, w));
        p.z = 32'(clip_quotient(1'b1, 64'd1 << 40, w));
        p.valid = 1'b1;
      end
      p.last = (col == FRAME_WIDTH - 1) && (row == FRAME_HEIGHT - 1);
      p.red = r;
      p.green = g;
      p.blue = b;
      expected_q.push_back(p);
      col++;
      if (col >= FRAME_WIDTH) begin
        col = 0;
        row++;
        if (row >= FRAME_HEIGHT) row = 0;
      end
    endfunction

    task report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      // keep the log short on a systematic failure
      if (mismatches < REPORT_CAP)
        $display("point %0d %s: expected %h, got %h", checked, field, want, got);
      mismatches++;
    endtask

    task check_point(logic [119:0] data, logic valid, logic last);
      point_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch("arrived with nothing expected", '0, data[31:0]);
        return;
      end
      want = expected_q.pop_front();
      if (data[31:0] !== want.x) report_mismatch("point_x", want.x, data[31:0]);
      if (data[63:32] !== want.y) report_mismatch("point_y", want.y, data[63:32]);
      if (data[95:64] !== want.z) report_mismatch("point_z", want.z, data[95:64]);
      if (data[103:96] !== want.red) report_mismatch("point_red", want.red, data[103:96]);
      if (data[111:104] !== want.green)
        report_mismatch("point_green", want.green, data[111:104]);
      if (data[119:112] !== want.blue)
        report_mismatch("point_blue", want.blue, data[119:112]);
      if (valid !== want.valid) report_mismatch("point_valid", want.valid, valid);
      if (last !== want.last) report_mismatch("frame_last", want.last, last);
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  point_tracker sb;
  bit           tx_busy;
  bit           rx_busy;
  int unsigned  rx_gap;
  int           ready_wait;
  int           cycles;

  depth_pixel_to_point dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // Check each accepted point, then, unless rx_busy is set, hold ready low for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_wait <= 0;
    end else if (out_tvalid && out_tready) begin
      sb.check_point(out_tdata, out_tuser, out_tlast);
      rx_gap = rx_busy ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_gap != 0) begin
        out_tready <= 1'b0;
        ready_wait <= rx_gap;
      end
    end else if (!out_tready) begin
      if (ready_wait <= 1) out_tready <= 1'b1;
      ready_wait <= ready_wait - 1;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_pixel(logic [10:0] depth, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic start);
    int unsigned gap;
    gap = tx_busy ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, b, g, r, depth};
    in_tuser <= start;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_pixel(depth, r, g, b, start);
  endtask

  // Stop sending and wait until every expected point is out.
  task automatic wait_points_done();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write.
  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic load_regs(logic [31:0] sx, logic [31:0] sy, logic [31:0] cx,
                           logic [31:0] cy, logic [31:0] g, logic [31:0] o);
    set_reg(CFG_SCALE_X, sx);
    set_reg(CFG_SCALE_Y, sy);
    set_reg(CFG_CENTER_X, cx);
    set_reg(CFG_CENTER_Y, cy);
    set_reg(CFG_DEPTH_GAIN, g);
    set_reg(CFG_DEPTH_OFFSET, o);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] draw_scale();
    case ($urandom_range(0, 4))
      0, 1: return $urandom_range(10000, 60000);
      2: return 32'd0 - $urandom_range(10000, 60000);
      3: return $urandom();
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic shuffle_regs();
    logic [31:0] g;
    logic [31:0] o;
    if ($urandom_range(0, 1)) set_reg(CFG_SCALE_X, draw_scale());
    if ($urandom_range(0, 1)) set_reg(CFG_SCALE_Y, draw_scale());
    if ($urandom_range(0, 1)) set_reg(CFG_CENTER_X, $urandom_range(0, 16383));
    if ($urandom_range(0, 1)) set_reg(CFG_CENTER_Y, $urandom_range(0, 16383));
    if ($urandom_range(0, 1)) begin
      // mostly a camera-like falling line, positive at depth 0, that may cross zero inside the depth range
      if ($urandom_range(0, 3) != 0) begin
        g = 32'd0 - $urandom_range(20000, 80000);
        o = $urandom_range(30_000_000, 120_000_000);
      end else begin
        g = $urandom();
        o = $urandom();
      end
      set_reg(CFG_DEPTH_GAIN, g);
      set_reg(CFG_DEPTH_OFFSET, o);
    end
    if ($urandom_range(0, 4) == 0) set_reg(IDX_SPARE_HI, $urandom());
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    tx_busy = 1'b0;
    rx_busy = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Calibration defaults: near and far valid points, both sides of w = 0.
    send_pixel(11'd0, 8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(11'd2047, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(11'd1084, 8'h55, 8'hAA, 8'h0F, 1'b0);
    send_pixel(11'd1085, 8'hF0, 8'h0F, 8'h5A, 1'b0);
    send_pixel(11'd1, 8'h01, 8'h80, 8'h7F, 1'b0);
    wait_points_done();

    // Smallest positive w with extreme scales: every coordinate saturates.
    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'd16383, 32'd16383, 32'd0, 32'd1);
    send_pixel(11'd0, 8'h12, 8'h34, 8'h56, 1'b1);
    send_pixel(11'd2047, 8'hFF, 8'h00, 8'hFF, 1'b0);
    send_pixel(11'd1024, 8'h00, 8'hFF, 8'h00, 1'b0);
    wait_points_done();

    // Largest w; writes to undecoded indexes must change nothing.
    load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    set_reg(IDX_SPARE_LO, 32'h0000_3FFF);
    set_reg(IDX_SPARE_HI, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    send_pixel(11'd0, 8'hAA, 8'h55, 8'hAA, 1'b1);
    send_pixel(11'd2047, 8'h3C, 8'hC3, 8'h99, 1'b0);
    send_pixel(11'd1365, 8'h66, 8'h99, 8'h33, 1'b0);
    wait_points_done();

    // Most negative gain: w positive at depth 0 only.
    set_reg(CFG_DEPTH_GAIN, 32'h8000_0000);
    set_reg(CFG_DEPTH_OFFSET, 32'h7FFF_FFFF);
    cfg_we <= 1'b0;
    send_pixel(11'd0, 8'h11, 8'h22, 8'h33, 1'b1);
    send_pixel(11'd1, 8'h44, 8'h55, 8'h66, 1'b0);
    send_pixel(11'd2047, 8'h77, 8'h88, 8'h99, 1'b0);
    wait_points_done();

    // w exactly zero, then most negative offset.
    set_reg(CFG_DEPTH_GAIN, 32'd0);
    set_reg(CFG_DEPTH_OFFSET, 32'd0);
    cfg_we <= 1'b0;
    send_pixel(11'd777, 8'hC0, 8'hDE, 8'hEF, 1'b0);
    wait_points_done();
    set_reg(CFG_DEPTH_OFFSET, 32'h8000_0000);
    cfg_we <= 1'b0;
    send_pixel(11'd1500, 8'hBE, 8'hEF, 8'hCA, 1'b0);
    wait_points_done();

    // Back to the calibration defaults; counters carry on without a frame start.
    load_regs(RST_SCALE_X, RST_SCALE_Y, RST_CENTER_X, RST_CENTER_Y,
              RST_DEPTH_GAIN, RST_DEPTH_OFFSET);
    send_pixel(11'd500, 8'h01, 8'h02, 8'h03, 1'b0);
    send_pixel(11'd600, 8'h04, 8'h05, 8'h06, 1'b0);
    send_pixel(11'd700, 8'h07, 8'h08, 8'h09, 1'b0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_points_done();
      shuffle_regs();
      tx_busy = ($urandom_range(0, 3) == 0);
      rx_busy = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 79) == 0) wait_points_done();
        send_pixel($urandom_range(0, 2047), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 149) == 0);
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ depth_pixel_to_point.f @@
+incdir+hdl
hdl/dpp_pkg.sv
hdl/dpp_mul.sv
hdl/dpp_div.sv
hdl/dpp_pos.sv
hdl/depth_pixel_to_point.sv
verif/tb.sv
